[rtl/slpc_pkg.sv]
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types and constants of the status LED pattern controller: request
// and result payloads, operation and mode codes, register indexes.
// ----------------------------------------------------------------------------
package slpc_pkg;

    localparam int PERIOD_W       = 16;
    localparam int LEVEL_W        = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int DIV_DIVIDEND_W = PERIOD_W + LEVEL_W;
    localparam int DIV_DIVISOR_W  = PERIOD_W - 1;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_RUN_EVENT    = 3'd1,
        OP_SUB_EVENT    = 3'd2,
        OP_POWER_OFF    = 3'd3,
        OP_APPLY_CONFIG = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_ON      = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_BREATHE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY_MANUAL  = 3'd0,
        CFG_MANUAL_MODE    = 3'd1,
        CFG_MANUAL_HALF    = 3'd2,
        CFG_MANUAL_PERIOD  = 3'd3,
        CFG_CHARGE_PERIOD  = 3'd4,
        CFG_ACTIVE_HIGH    = 3'd5
    } cfg_idx_t;

    // run states
    localparam logic [2:0] RUN_OFF      = 3'd0;
    localparam logic [2:0] RUN_SHUTDOWN = 3'd1;
    localparam logic [2:0] RUN_BOOT     = 3'd2;
    localparam logic [2:0] RUN_IDLE     = 3'd3;

    // sub flag bit positions
    localparam int SUB_USB      = 0;
    localparam int SUB_CHARGING = 1;
    localparam int SUB_BATT_LOW = 2;
    localparam int SUB_TRANSFER = 3;

    localparam logic [PERIOD_W-1:0] BOOT_BLINK_HALF     = 16'd150;
    localparam logic [PERIOD_W-1:0] TRANSFER_BLINK_HALF = 16'd120;
    localparam logic [PERIOD_W-1:0] BATTERY_BLINK_HALF  = 16'd200;
    localparam logic [PERIOD_W-1:0] IDLE_BREATHE_PERIOD = 16'd3000;
    localparam logic [PERIOD_W-1:0] RST_BLINK_HALF      = 16'd250;
    localparam logic [PERIOD_W-1:0] RST_BREATHE_PERIOD  = 16'd2000;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX           = 8'd255;

    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] sys_state;
        logic [5:0] sub_flags;
        logic [5:0] changed_flags;
    } in_item_t;

    typedef struct packed {
        logic               pin_level;
        logic [1:0]         current_mode;
        logic [LEVEL_W-1:0] brightness;
    } out_item_t;

    typedef struct packed {
        mode_t               mode;
        logic                set_blink_half;
        logic [PERIOD_W-1:0] blink_half;
        logic                set_breathe_period;
        logic [PERIOD_W-1:0] breathe_period;
    } policy_t;

    function automatic logic [PERIOD_W-1:0] at_least_one(input logic [PERIOD_W-1:0] v);
        return (v == '0) ? PERIOD_W'(1) : v;
    endfunction

endpackage

[rtl/slpc_policy.sv]
// ----------------------------------------------------------------------------
// slpc_policy
// System policy decode: maps run state and sub-state flags to a mode and,
// where the mode needs one, a blink half period or breathe period.
// ----------------------------------------------------------------------------
module slpc_policy (
    input  logic [2:0]                    sys_state,
    input  logic [5:0]                    sub_flags,
    input  logic [slpc_pkg::PERIOD_W-1:0] charge_period,
    output slpc_pkg::policy_t             policy
);
    import slpc_pkg::*;

    always_comb begin
        policy = '{mode: MODE_ON, set_blink_half: 1'b0, blink_half: BOOT_BLINK_HALF,
                   set_breathe_period: 1'b0, breathe_period: IDLE_BREATHE_PERIOD};
        priority if (sys_state == RUN_OFF || sys_state == RUN_SHUTDOWN) begin
            policy.mode = MODE_OFF;
        end else if (sys_state == RUN_BOOT) begin
            policy.mode           = MODE_BLINK;
            policy.set_blink_half = 1'b1;
            policy.blink_half     = BOOT_BLINK_HALF;
        end else if (sub_flags[SUB_TRANSFER]) begin
            policy.mode           = MODE_BLINK;
            policy.set_blink_half = 1'b1;
            policy.blink_half     = TRANSFER_BLINK_HALF;
        end else if (sub_flags[SUB_BATT_LOW]) begin
            policy.mode           = MODE_BLINK;
            policy.set_blink_half = 1'b1;
            policy.blink_half     = BATTERY_BLINK_HALF;
        end else if (sub_flags[SUB_USB] && !sub_flags[SUB_CHARGING]) begin
            policy.mode = MODE_OFF;
        end else if (sub_flags[SUB_CHARGING]) begin
            policy.mode               = MODE_BREATHE;
            policy.set_breathe_period = 1'b1;
            policy.breathe_period     = at_least_one(charge_period);
        end else if (sys_state == RUN_IDLE) begin
            policy.mode               = MODE_BREATHE;
            policy.set_breathe_period = 1'b1;
            policy.breathe_period     = IDLE_BREATHE_PERIOD;
        end else begin
            policy.mode = MODE_ON;
        end
    end

endmodule

[rtl/slpc_div.sv]
// ----------------------------------------------------------------------------
// slpc_div
// Restoring divider, one quotient bit per cycle, for the breathe
// triangle brightness.
// ----------------------------------------------------------------------------
module slpc_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [slpc_pkg::DIV_DIVIDEND_W-1:0] dividend,
    input  logic [slpc_pkg::DIV_DIVISOR_W-1:0]  divisor,
    output logic                                done,
    output logic [slpc_pkg::DIV_DIVIDEND_W-1:0] quotient
);
    import slpc_pkg::*;

    localparam int CNT_W = $clog2(DIV_DIVIDEND_W);

    logic [DIV_DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIV_DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIV_DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      active_reg, active_next;
    logic                      done_reg, done_next;

    logic [DIV_DIVISOR_W:0]    rem_shift;
    logic [DIV_DIVISOR_W+1:0]  diff;
    logic                      fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_DIVIDEND_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign fits      = !diff[DIV_DIVISOR_W+1];

    always_comb begin
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (start) begin
            quo_next    = dividend;
            rem_next    = '0;
            dvs_next    = divisor;
            cnt_next    = CNT_W'(DIV_DIVIDEND_W - 1);
            active_next = 1'b1;
        end else if (active_reg) begin
            quo_next = {quo_reg[DIV_DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIV_DIVISOR_W-1:0] : rem_shift[DIV_DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/status_led_pattern_controller.sv]
// ----------------------------------------------------------------------------
// status_led_pattern_controller
// Status LED driver with off, on, blink and breathe modes, software PWM and
// a system state policy.
// ----------------------------------------------------------------------------
// an accepted request passes S_DONE before its result is registered; a breathe
//   tick first passes S_PREP and the 24-step serial divider forming the triangle brightness
// a new request is taken only in S_IDLE, after the last result has been registered;
//   a result waiting on m_ready stalls input only once the next one is done
// reset: synchronous active-low aresetn, registers back to their reset values
module status_led_pattern_controller #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  slpc_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output slpc_pkg::out_item_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [slpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import slpc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    mode_t                   mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0]  blink_count_reg, blink_count_next;
    logic [COUNT_WIDTH-1:0]  breathe_count_reg, breathe_count_next;
    logic                    blink_level_reg, blink_level_next;
    logic [LEVEL_W-1:0]      breathe_level_reg, breathe_level_next;
    logic [LEVEL_W-1:0]      pwm_phase_reg, pwm_phase_next;
    logic [PERIOD_W-1:0]     blink_half_reg, blink_half_next;
    logic [PERIOD_W-1:0]     breathe_period_reg, breathe_period_next;
    logic                    lit_reg, lit_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic                    policy_manual_reg;
    mode_t                   manual_mode_reg;
    logic [PERIOD_W-1:0]     manual_half_reg;
    logic [PERIOD_W-1:0]     manual_period_reg;
    logic [PERIOD_W-1:0]     charge_period_reg;
    logic                    active_high_reg;

    policy_t                 policy;
    op_t                     op;
    logic                    set_req;
    mode_t                   set_mode;
    logic                    use_policy;

    logic [COUNT_WIDTH-1:0]  blink_inc, breathe_inc;
    logic [CMP_W-1:0]        pos_ext;
    logic [PERIOD_W-1:0]     pos, pos_fold;
    logic [DIV_DIVISOR_W-1:0] half;

    logic                    div_start, div_done;
    logic [DIV_DIVIDEND_W-1:0] dividend, quotient;
    logic [LEVEL_W-1:0]      level_sat;

    slpc_policy u_policy (
        .sys_state     (s_data.sys_state),
        .sub_flags     (s_data.sub_flags),
        .charge_period (charge_period_reg),
        .policy        (policy)
    );

    slpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (half),
        .done     (div_done),
        .quotient (quotient)
    );

    assign op          = op_t'(s_data.operation);
    assign blink_inc   = blink_count_reg + 1'b1;
    assign breathe_inc = breathe_count_reg + 1'b1;

    // triangle operands from the stored phase count, which stays below the period
    assign pos_ext  = CMP_W'(breathe_count_reg);
    assign pos      = pos_ext[PERIOD_W-1:0];
    assign half     = breathe_period_reg[PERIOD_W-1:1];
    assign pos_fold = (pos >= {1'b0, half}) ? (breathe_period_reg - pos) : pos;
    assign dividend = DIV_DIVIDEND_W'(pos_fold) * DIV_DIVIDEND_W'(LEVEL_MAX);
    assign level_sat = (quotient > DIV_DIVIDEND_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                               : quotient[LEVEL_W-1:0];

    always_comb begin
        state_next          = state_reg;
        mode_next           = mode_reg;
        blink_count_next    = blink_count_reg;
        breathe_count_next  = breathe_count_reg;
        blink_level_next    = blink_level_reg;
        breathe_level_next  = breathe_level_reg;
        pwm_phase_next      = pwm_phase_reg;
        blink_half_next     = blink_half_reg;
        breathe_period_next = breathe_period_reg;
        lit_next            = lit_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_data_next         = m_data_reg;
        div_start           = 1'b0;
        set_req             = 1'b0;
        set_mode            = MODE_OFF;
        use_policy          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DONE;
                    unique case (op)
                        OP_TICK: begin
                            unique case (mode_reg)
                                MODE_BLINK: begin
                                    if (CMP_W'(blink_inc) >= CMP_W'(blink_half_reg)) begin
                                        blink_count_next = '0;
                                        blink_level_next = !blink_level_reg;
                                        lit_next         = !blink_level_reg;
                                    end else begin
                                        blink_count_next = blink_inc;
                                        lit_next         = blink_level_reg;
                                    end
                                end
                                MODE_BREATHE: begin
                                    if (CMP_W'(breathe_inc) >= CMP_W'(breathe_period_reg)) begin
                                        breathe_count_next = '0;
                                    end else begin
                                        breathe_count_next = breathe_inc;
                                    end
                                    pwm_phase_next = pwm_phase_reg + 1'b1;
                                    state_next     = S_PREP;
                                end
                                MODE_ON:  lit_next = 1'b1;
                                MODE_OFF: lit_next = 1'b0;
                                default:  lit_next = 1'b0;
                            endcase
                        end
                        OP_RUN_EVENT: begin
                            use_policy = !policy_manual_reg;
                        end
                        OP_SUB_EVENT: begin
                            use_policy = !policy_manual_reg && (s_data.changed_flags != '0);
                        end
                        OP_POWER_OFF: begin
                            set_req  = 1'b1;
                            set_mode = MODE_OFF;
                        end
                        OP_APPLY_CONFIG: begin
                            if (policy_manual_reg) begin
                                set_req             = 1'b1;
                                set_mode            = manual_mode_reg;
                                blink_half_next     = at_least_one(manual_half_reg);
                                breathe_period_next = at_least_one(manual_period_reg);
                            end else begin
                                use_policy = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PREP: begin
                if (half == '0) begin
                    breathe_level_next = LEVEL_MAX;
                    lit_next           = pwm_phase_reg < LEVEL_MAX;
                    state_next         = S_DONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    breathe_level_next = level_sat;
                    lit_next           = pwm_phase_reg < level_sat;
                    state_next         = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.pin_level    = lit_reg ^ !active_high_reg;
                    m_data_next.current_mode = mode_reg;
                    m_data_next.brightness   = breathe_level_reg;
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (use_policy) begin
            set_req  = 1'b1;
            set_mode = policy.mode;
            if (policy.set_blink_half) begin
                blink_half_next = policy.blink_half;
            end
            if (policy.set_breathe_period) begin
                breathe_period_next = policy.breathe_period;
            end
        end

        // mode set clears counters and renders at once
        if (set_req) begin
            mode_next          = set_mode;
            blink_count_next   = '0;
            breathe_count_next = '0;
            blink_level_next   = 1'b0;
            pwm_phase_next     = '0;
            unique case (set_mode)
                MODE_ON: begin
                    breathe_level_next = LEVEL_MAX;
                    lit_next           = 1'b1;
                end
                MODE_OFF: begin
                    breathe_level_next = '0;
                    lit_next           = 1'b0;
                end
                MODE_BLINK: begin
                    lit_next = 1'b0;
                end
                MODE_BREATHE: begin
                    pwm_phase_next = LEVEL_W'(1);
                    lit_next       = LEVEL_W'(1) < breathe_level_reg;
                end
                default: lit_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            mode_reg           <= MODE_OFF;
            blink_count_reg    <= '0;
            breathe_count_reg  <= '0;
            blink_level_reg    <= 1'b0;
            breathe_level_reg  <= '0;
            pwm_phase_reg      <= '0;
            blink_half_reg     <= RST_BLINK_HALF;
            breathe_period_reg <= RST_BREATHE_PERIOD;
            lit_reg            <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg          <= state_next;
            mode_reg           <= mode_next;
            blink_count_reg    <= blink_count_next;
            breathe_count_reg  <= breathe_count_next;
            blink_level_reg    <= blink_level_next;
            breathe_level_reg  <= breathe_level_next;
            pwm_phase_reg      <= pwm_phase_next;
            blink_half_reg     <= blink_half_next;
            breathe_period_reg <= breathe_period_next;
            lit_reg            <= lit_next;
            m_valid_reg        <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_manual_reg <= 1'b0;
            manual_mode_reg   <= MODE_ON;
            manual_half_reg   <= RST_BLINK_HALF;
            manual_period_reg <= RST_BREATHE_PERIOD;
            charge_period_reg <= RST_BREATHE_PERIOD;
            active_high_reg   <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_POLICY_MANUAL: policy_manual_reg <= cfg_data[0];
                CFG_MANUAL_MODE:   manual_mode_reg   <= mode_t'(cfg_data[1:0]);
                CFG_MANUAL_HALF:   manual_half_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_MANUAL_PERIOD: manual_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_CHARGE_PERIOD: charge_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_ACTIVE_HIGH:   active_high_reg   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

[rtl/slpc_checker.sv]
// ----------------------------------------------------------------------------
// slpc_checker
// Port-level checks of the status LED pattern controller, bound to the top.
// ----------------------------------------------------------------------------
module slpc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input slpc_pkg::out_item_t m_data
);
    import slpc_pkg::*;

    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.current_mode == MODE_OFF |-> m_data.brightness == '0)
        else $error("off mode with nonzero brightness");

    a_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.current_mode == MODE_ON |-> m_data.brightness == LEVEL_MAX)
        else $error("on mode without full brightness");

endmodule

bind status_led_pattern_controller slpc_checker u_slpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
